@@ hdl/mfap_pkg.sv @@
// Shared types and constants for the max-flow augmenting-path engine.
// No dependencies; imported by the top level.
package mfap_pkg;

   localparam int NODES_DEF  = 64;
   localparam int FLOW_W     = 14;
   localparam int ENTRY_W    = 9;
   localparam int CAP_W      = 8;
   localparam int FIELD_W    = 6;
   localparam int CSR_ADDR_W = 3;
   localparam logic [FLOW_W-1:0] FLOW_MAX = {FLOW_W{1'b1}};

   typedef enum logic [1:0] {
      KIND_CLEAR = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_RUN   = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   localparam logic [CSR_ADDR_W-1:0] REG_TARGET_FLOW = 3'd0;

endpackage

@@ hdl/max_flow_augmenting_path_top.sv @@
// Top level of the max-flow engine: sequencer, residual/parent/queue RAMs.
// Depends on mfap_pkg and mfap_ram.
//
// Clear, write and run beats on the request stream; only a run returns a
// response beat (total flow, target met). A clear sweeps the residual RAM
// one entry a cycle, and the same sweep runs after reset before the first
// beat is taken. A run is a chain of breadth-first searches through one
// residual RAM port: each popped node scans its row at one entry a cycle,
// and each path found is walked back from the sink for the bottleneck,
// then again to subtract it forward and add it in reverse; the run ends
// with a search that finds no path. The request side stays not ready while
// a beat is in work.
module max_flow_augmenting_path_top #(
   parameter int NODES = mfap_pkg::NODES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [23:0]                   req_tdata,  // from_node, to_node, capacity, pad
   input  logic [1:0]                    req_tuser,  // kind
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [15:0]                   rsp_tdata,  // total_flow, target_met, pad
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [mfap_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);
   import mfap_pkg::*;

   localparam int NODE_W = $clog2(NODES);
   localparam int ADDR_W = $clog2(NODES * NODES);
   localparam int CNT_W  = NODE_W + 1;
   localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODES - 1);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NODES * NODES - 1);
   localparam logic [CNT_W-1:0]  NODE_CNT  = CNT_W'(NODES);
   localparam logic [ENTRY_W:0]  NODE_LIM  = (ENTRY_W+1)'(NODES);
   localparam logic [NODE_W-1:0] SRC  = '0;
   localparam logic [NODE_W-1:0] SINK = NODE_W'(1);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_INIT, S_POP, S_POPW, S_CHK,
      S_BOT_P, S_BOT_PW, S_BOT_C,
      S_AUG_P, S_AUG_PW, S_AUG_F, S_AUG_R,
      S_SUM, S_FIN
   } state_type;

   state_type            state_ff;
   logic [ADDR_W-1:0]    clr_ff;
   logic [FLOW_W-1:0]    target_ff;
   logic [FLOW_W-1:0]    flow_ff;
   logic [ENTRY_W-1:0]   best_ff;
   logic [NODE_W-1:0]    u_ff, v_ff;
   logic [CNT_W-1:0]     head_ff, tail_ff, steps_ff;
   logic [NODES-1:0]     visited_ff;
   logic                 rsp_valid_ff;
   logic [FLOW_W-1:0]    rsp_flow_ff;
   logic                 rsp_met_ff;

   logic                 res_we;
   logic [ADDR_W-1:0]    res_waddr, res_raddr;
   logic [ENTRY_W-1:0]   res_wdata, res_rdata;
   logic                 par_we;
   logic [NODE_W-1:0]    par_waddr, par_wdata, par_raddr, par_rdata;
   logic                 q_we;
   logic [NODE_W-1:0]    q_waddr, q_wdata, q_raddr, q_rdata;

   logic [NODE_W-1:0]    req_from, req_to;
   logic [CAP_W-1:0]     req_cap;
   logic                 req_fire, req_in_range, edge_hit, chk_last;
   kind_type             req_kind;
   logic [FLOW_W:0]      flow_sum_in;
   logic                 csr_wr;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [NODE_W-1:0] r,
                                                   input logic [NODE_W-1:0] c);
      cell_addr = ADDR_W'(ADDR_W'(r) * ADDR_W'(NODES)) + ADDR_W'(c);
   endfunction

   assign req_kind     = kind_type'(req_tuser);
   assign req_from     = NODE_W'(req_tdata[5:0]);
   assign req_to       = NODE_W'(req_tdata[11:6]);
   assign req_cap      = req_tdata[19:12];
   assign req_in_range = ((ENTRY_W+1)'(req_tdata[5:0]) < NODE_LIM) &&
                         ((ENTRY_W+1)'(req_tdata[11:6]) < NODE_LIM);
   assign req_tready   = (state_ff == S_IDLE);
   assign req_fire     = req_tvalid && req_tready;
   assign edge_hit     = (res_rdata != '0) && !visited_ff[v_ff];
   assign chk_last     = (v_ff == LAST_NODE);
   assign flow_sum_in  = (FLOW_W+1)'(flow_ff) + (FLOW_W+1)'(best_ff);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_met_ff, rsp_flow_ff};

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr == REG_TARGET_FLOW) ? 32'(target_ff) : '0;

   // RAM port steering
   always_comb begin
      res_we    = 1'b0;
      res_waddr = cell_addr(u_ff, v_ff);
      res_wdata = '0;
      res_raddr = cell_addr(u_ff, v_ff);
      par_we    = 1'b0;
      par_waddr = v_ff;
      par_wdata = u_ff;
      par_raddr = v_ff;
      q_we      = 1'b0;
      q_waddr   = tail_ff[NODE_W-1:0];
      q_wdata   = v_ff;
      q_raddr   = head_ff[NODE_W-1:0];
      case (state_ff)
         S_CLEAR: begin
            res_we    = 1'b1;
            res_waddr = clr_ff;
         end
         S_IDLE: begin
            if (req_fire && req_kind == KIND_WRITE && req_in_range) begin
               res_we    = 1'b1;
               res_waddr = cell_addr(req_from, req_to);
               res_wdata = ENTRY_W'(req_cap);
            end
         end
         S_INIT: begin
            q_we    = 1'b1;
            q_waddr = '0;
            q_wdata = SRC;
         end
         S_POPW: res_raddr = cell_addr(q_rdata, '0);
         S_CHK: begin
            res_raddr = cell_addr(u_ff, v_ff + NODE_W'(1));
            if (edge_hit) begin
               par_we = 1'b1;
               q_we   = (tail_ff < NODE_CNT);
            end
         end
         S_BOT_PW: res_raddr = cell_addr(par_rdata, v_ff);
         S_AUG_PW: res_raddr = cell_addr(par_rdata, v_ff);
         S_AUG_F: begin
            res_we    = 1'b1;
            res_waddr = cell_addr(u_ff, v_ff);
            res_wdata = res_rdata - best_ff;
            res_raddr = cell_addr(v_ff, u_ff);
         end
         S_AUG_R: begin
            res_we    = 1'b1;
            res_waddr = cell_addr(v_ff, u_ff);
            res_wdata = res_rdata + best_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         target_ff    <= '0;
         flow_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         steps_ff     <= '0;
         visited_ff   <= '0;
      end else begin
         if (csr_wr && csr_paddr == REG_TARGET_FLOW) begin
            target_ff <= csr_pwdata[FLOW_W-1:0];
         end
         if (rsp_valid_ff && rsp_tready && state_ff != S_FIN) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + ADDR_W'(1);
               if (clr_ff == LAST_ADDR) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_fire) begin
                  case (req_kind)
                     KIND_CLEAR: begin
                        clr_ff   <= '0;
                        state_ff <= S_CLEAR;
                     end
                     KIND_RUN: begin
                        flow_ff  <= '0;
                        state_ff <= S_INIT;
                     end
                     default: ;
                  endcase
               end
            end
            S_INIT: begin
               visited_ff <= NODES'(1);
               head_ff    <= '0;
               tail_ff    <= CNT_W'(1);
               state_ff   <= S_POP;
            end
            S_POP: begin
               if (head_ff < tail_ff) begin
                  head_ff  <= head_ff + CNT_W'(1);
                  state_ff <= S_POPW;
               end else begin
                  state_ff <= S_FIN;
               end
            end
            S_POPW: begin
               u_ff     <= q_rdata;
               v_ff     <= '0;
               state_ff <= S_CHK;
            end
            S_CHK: begin
               if (edge_hit) begin
                  visited_ff[v_ff] <= 1'b1;
                  if (tail_ff < NODE_CNT) begin
                     tail_ff <= tail_ff + CNT_W'(1);
                  end
               end
               if (edge_hit && v_ff == SINK) begin
                  // sink reached: walk the path back for the bottleneck
                  best_ff  <= '1;
                  v_ff     <= SINK;
                  steps_ff <= '0;
                  state_ff <= S_BOT_P;
               end else if (chk_last) begin
                  state_ff <= S_POP;
               end else begin
                  v_ff <= v_ff + NODE_W'(1);
               end
            end
            S_BOT_P: state_ff <= S_BOT_PW;
            S_BOT_PW: begin
               u_ff     <= par_rdata;
               state_ff <= S_BOT_C;
            end
            S_BOT_C: begin
               if (res_rdata < best_ff) begin
                  best_ff <= res_rdata;
               end
               v_ff     <= u_ff;
               steps_ff <= steps_ff + CNT_W'(1);
               if (u_ff == SRC || steps_ff + CNT_W'(1) == NODE_CNT) begin
                  v_ff     <= SINK;
                  steps_ff <= '0;
                  state_ff <= S_AUG_P;
               end else begin
                  state_ff <= S_BOT_P;
               end
            end
            S_AUG_P: state_ff <= S_AUG_PW;
            S_AUG_PW: begin
               u_ff     <= par_rdata;
               state_ff <= S_AUG_F;
            end
            S_AUG_F: state_ff <= S_AUG_R;
            S_AUG_R: begin
               v_ff     <= u_ff;
               steps_ff <= steps_ff + CNT_W'(1);
               if (u_ff == SRC || steps_ff + CNT_W'(1) == NODE_CNT) begin
                  state_ff <= S_SUM;
               end else begin
                  state_ff <= S_AUG_P;
               end
            end
            S_SUM: begin
               // saturate the running total
               flow_ff  <= flow_sum_in[FLOW_W] ? FLOW_MAX : flow_sum_in[FLOW_W-1:0];
               state_ff <= S_INIT;
            end
            S_FIN: begin
               // hold until the previous response beat is gone
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_flow_ff  <= flow_ff;
                  rsp_met_ff   <= (flow_ff == target_ff);
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   mfap_ram #(.WIDTH(ENTRY_W), .DEPTH(NODES * NODES)) u_residual (
      .clock(clock), .we(res_we), .waddr(res_waddr), .wdata(res_wdata),
      .raddr(res_raddr), .rdata(res_rdata)
   );

   mfap_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_parent (
      .clock(clock), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
      .raddr(par_raddr), .rdata(par_rdata)
   );

   mfap_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_queue (
      .clock(clock), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
      .raddr(q_raddr), .rdata(q_rdata)
   );

`ifndef SYNTHESIS
   a_tail_ahead: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POP || state_ff == S_CHK) |-> (head_ff <= tail_ff))
      else $error("queue head passed tail");
   a_src_visited: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHK) |-> visited_ff[0])
      else $error("source not marked during scan");
   a_best_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_AUG_F || state_ff == S_SUM) |-> (best_ff != '0))
      else $error("zero bottleneck on a found path");
   a_fin_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && (!rsp_valid_ff || rsp_tready)) |=> rsp_valid_ff)
      else $error("run finished without response beat");
`endif
endmodule

@@ hdl/mfap_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mfap_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

@@ verif/max_flow_augmenting_path_top_tb.sv @@
// Self-checking testbench for max_flow_augmenting_path_top: stream driver/monitor,
// APB writes of target_flow, and an in-bench max-flow predictor.
// Depends on mfap_pkg and the RTL under hdl/.
module max_flow_augmenting_path_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mfap_pkg::*;

   typedef struct {
      kind_type   kind;
      logic [5:0] from_node;
      logic [5:0] to_node;
      logic [7:0] capacity;
   } flow_req_type;

   typedef struct {
      logic [13:0] total_flow;
      logic        target_met;
   } flow_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // from_node, to_node, capacity, pad
   logic [1:0]  req_tuser = KIND_NONE;  // kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // total_flow, target_met, pad
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   max_flow_augmenting_path_top u_dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   logic [8:0]  resid_mx [0:4095];
   logic [13:0] target_reg = '0;

   flow_req_type pending_reqs[$];
   flow_rsp_type expected_flows[$];
   flow_req_type driven_req;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          hold_target = 0;
   int          hold_count = 0;
   int          errors = 0;
   int          beats_in = 0;
   int          beats_out = 0;
   int          met_seen = 0;

   function automatic logic [13:0] solve_max_flow();
      bit      seen [0:63];
      int      par [0:63];
      int      bfs_q [0:63];
      int      head, tail, u, v, steps;
      int      best, gain, sum;
      bit      found;
      sum  = 0;
      gain = 1;
      while (gain != 0) begin
         gain = 0;
         foreach (seen[i]) seen[i] = 0;
         seen[0] = 1;
         head = 0;
         tail = 1;
         bfs_q[0] = 0;
         found = 0;
         while (head < tail && !found) begin
            u = bfs_q[head];
            head++;
            for (v = 0; v < 64 && !found; v++) begin
               if (resid_mx[u*64+v] != 0 && !seen[v]) begin
                  seen[v] = 1;
                  par[v] = u;
                  if (tail < 64) begin
                     bfs_q[tail] = v;
                     tail++;
                  end
                  if (v == 1) found = 1;
               end
            end
         end
         if (found) begin
            best = resid_mx[par[1]*64+1];
            v = 1;
            steps = 0;
            while (v != 0 && steps < 64) begin
               u = par[v];
               if (resid_mx[u*64+v] < best) best = resid_mx[u*64+v];
               v = u;
               steps++;
            end
            v = 1;
            steps = 0;
            while (v != 0 && steps < 64) begin
               u = par[v];
               resid_mx[u*64+v] = resid_mx[u*64+v] - best[8:0];
               resid_mx[v*64+u] = resid_mx[v*64+u] + best[8:0];
               v = u;
               steps++;
            end
            gain = best;
            sum += gain;
            if (sum > 16383) sum = 16383;
         end
      end
      return sum[13:0];
   endfunction

   function automatic void apply_req(flow_req_type r);
      flow_rsp_type e;
      case (r.kind)
         KIND_CLEAR: foreach (resid_mx[i]) resid_mx[i] = '0;
         KIND_WRITE: resid_mx[r.from_node*64 + r.to_node] = {1'b0, r.capacity};
         KIND_RUN: begin
            e.total_flow = solve_max_flow();
            e.target_met = (e.total_flow == target_reg);
            expected_flows = {expected_flows, e};
         end
         default: ;
      endcase
   endfunction

   // driver: keep valid up until accepted, then maybe present the next beat
   always @(posedge clock) begin : drv
      flow_req_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            apply_req(driven_req);
            beats_in++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               nxt = pending_reqs.pop_front();
               driven_req = nxt;
               req_tvalid <= 1'b1;
               req_tdata  <= {4'b0, nxt.capacity, nxt.to_node, nxt.from_node};
               req_tuser  <= nxt.kind;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (hold_count < hold_target) hold_count <= hold_count + 1;
   end

   always @(posedge clock) begin : mon
      flow_rsp_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         beats_out++;
         if (expected_flows.size() == 0) begin
            $error("unexpected result beat: total_flow=%0d", rsp_tdata[13:0]);
            errors++;
         end else begin
            e = expected_flows.pop_front();
            if (rsp_tdata[13:0] !== e.total_flow) begin
               $error("total_flow: expected %0d, actual %0d", e.total_flow, rsp_tdata[13:0]);
               errors++;
            end
            if (rsp_tdata[14] !== e.target_met) begin
               $error("target_met: expected %0d, actual %0d", e.target_met, rsp_tdata[14]);
               errors++;
            end
            if (e.target_met) met_seen++;
         end
      end
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= (hold_count >= hold_target) &&
                         ($urandom_range(0, 99) >= recv_stall_pct);
   end

   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [31:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (addr == REG_TARGET_FLOW) target_reg = data[13:0];
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   function automatic void push_req(kind_type k, int f, int t, int c);
      flow_req_type r;
      r.kind      = k;
      r.from_node = f[5:0];
      r.to_node   = t[5:0];
      r.capacity  = c[7:0];
      pending_reqs = {pending_reqs, r};
   endfunction

   function automatic int pick_node();
      if ($urandom_range(0, 7) == 0) return $urandom_range(0, 63);
      return $urandom_range(0, 7);
   endfunction

   // clear (sometimes), a few writes, then a run; rarely noise or a missing run
   function automatic int push_graph();
      int n, cnt;
      cnt = 0;
      if ($urandom_range(0, 2) == 0) begin
         push_req(KIND_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
         cnt++;
      end
      n = $urandom_range(2, 10);
      repeat (n) begin
         if ($urandom_range(0, 19) == 0)
            push_req(KIND_NONE, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
         else begin
            push_req(KIND_WRITE, pick_node(), pick_node(), $urandom_range(0, 255));
            cnt++;
         end
      end
      if ($urandom_range(0, 9) != 0) begin
         push_req(KIND_RUN, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
         cnt++;
      end
      return cnt;
   endfunction

   task automatic drain();
      // sample between edges so driver and monitor updates have settled
      while (pending_reqs.size() > 0 || req_tvalid || expected_flows.size() > 0)
         @(negedge clock);
      // a trailing clear may still be sweeping
      repeat (4200) @(posedge clock);
   endtask

   initial begin : stim
      int pct_send [4] = '{0, 65, 0, 31};
      int pct_recv [4] = '{0, 0, 65, 31};
      int done;
      foreach (resid_mx[i]) resid_mx[i] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      csr_write(REG_TARGET_FLOW, 32'd255);
      push_req(KIND_CLEAR, 63, 63, 255);
      push_req(KIND_RUN, 0, 0, 0);            // empty graph
      push_req(KIND_WRITE, 0, 1, 255);
      push_req(KIND_RUN, 63, 63, 255);        // single edge, meets target
      push_req(KIND_RUN, 0, 0, 0);            // repeated run adds nothing
      push_req(KIND_WRITE, 0, 2, 0);
      push_req(KIND_WRITE, 0, 3, 200);
      push_req(KIND_WRITE, 3, 63, 100);
      push_req(KIND_WRITE, 63, 1, 150);
      push_req(KIND_WRITE, 3, 1, 50);
      push_req(KIND_WRITE, 63, 63, 255);
      push_req(KIND_NONE, 63, 63, 255);       // unused kind
      push_req(KIND_NONE, 0, 0, 0);
      push_req(KIND_RUN, 42, 21, 170);
      push_req(KIND_WRITE, 1, 0, 255);        // reverse edge into source
      push_req(KIND_WRITE, 2, 1, 255);
      push_req(KIND_WRITE, 0, 2, 255);
      push_req(KIND_RUN, 21, 42, 85);
      push_req(KIND_CLEAR, 0, 0, 0);
      push_req(KIND_RUN, 0, 0, 0);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = pct_send[ph];
         recv_stall_pct = pct_recv[ph];
         case (ph)
            0: csr_write(REG_TARGET_FLOW, 32'd0);
            1: csr_write(REG_TARGET_FLOW, 32'd16065);
            default: csr_write(REG_TARGET_FLOW, $urandom_range(0, 600));
         endcase
         if (ph == 2) hold_target = hold_count + 3000;
         done = 0;
         while (done < 300) done += push_graph();
         drain();
      end

      $display("Covered %0d request beats and %0d result beats (%0d meeting target)",
               beats_in, beats_out, met_seen);
      $display("across four idle/stall mixes and four target_flow settings.");
      if (errors == 0 && expected_flows.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #100_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
